// ===== hw/rtl/cfd_pkg.sv =====
// Shared types and constants for the CAN serial frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = 88;

    typedef logic [7:0] t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes of the configuration port.
    localparam t_cfg_idx REG_HEADER  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_TRAILER = t_cfg_idx'(1);

    localparam t_byte HEADER_RESET  = 8'hAA;
    localparam t_byte TRAILER_RESET = 8'h7A;

    typedef struct packed {
        logic [31:0] payload_tail;
        logic [31:0] payload_head;
        logic [7:0]  length_code;
        logic [15:0] frame_id;
    } t_frame;

    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_win_res;

endpackage

// ===== hw/rtl/cfd_window.sv =====
// Sliding byte window, fill count and frame match for the deframer.
`timescale 1ns / 1ps

module cfd_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cfd_pkg::t_byte    i_byte,
    input  cfd_pkg::t_byte    i_header,
    input  cfd_pkg::t_byte    i_trailer,
    output cfd_pkg::t_win_res o_res
);
    import cfd_pkg::*;

    t_byte             r_window [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              w_full;
    logic              w_hit;

    assign w_full = (r_fill == FILL_W'(WIN_DEPTH));
    assign w_hit  = i_accept && w_full && (r_window[0] == i_header) && (i_byte == i_trailer);

    // Entry 0 is the oldest byte once the window is full.
    always_comb begin
        o_res.hit                = w_hit;
        o_res.frame.frame_id     = {r_window[6], r_window[7]};
        o_res.frame.length_code  = r_window[3];
        o_res.frame.payload_head = {r_window[11], r_window[10], r_window[9], r_window[8]};
        o_res.frame.payload_tail = {r_window[15], r_window[14], r_window[13], r_window[12]};
    end

    always_comb begin
        n_fill = r_fill;
        if (i_accept) begin
            if (w_hit) begin
                n_fill = '0;
            end else if (!w_full) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // The window content needs no reset: it is only read once sixteen bytes
    // have been shifted in since the last clear of the fill count.
    always_ff @(posedge i_clk) begin
        if (i_accept && !w_hit) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
            r_window[WIN_DEPTH-1] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/can_frame_deframer.sv =====
// Top level of the CAN serial frame deframer.
`timescale 1ns / 1ps

//  Channel   Direction  Width  Contents
//  s_axis    in         8      received serial byte
//  m_axis    out        88     decoded frame fields
//  cfg       in         8+8    register index and write data
//
// Each accepted byte is handled in the cycle it arrives: the window shift and
// the two byte compares sit between the window registers and the output
// register, so one byte per cycle is sustained while s_axis_tready is high;
// each found frame is registered. A two-deep output (register plus skid stage)
// lets a byte be taken while a frame waits downstream; only when both hold a
// frame does s_axis_tready fall. Reset is synchronous and active low; it
// empties the window and restores the default header and trailer values.

module can_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input byte stream.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
    // Decoded frames.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [cfd_pkg::OUT_W-1:0] m_axis_tdata,   // [15:0] frame_id,
                                                      // [23:16] length_code,
                                                      // [55:24] payload_head,
                                                      // [87:56] payload_tail
    // Configuration writes.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  cfd_pkg::t_cfg_idx         i_cfg_index,
    input  cfd_pkg::t_byte            i_cfg_data
);
    import cfd_pkg::*;

    t_byte    r_header;
    t_byte    r_trailer;
    logic     w_in_accept;
    logic     w_out_take;
    t_win_res w_res;

    t_frame   r_out;
    t_frame   n_out;
    logic     r_out_vld;
    logic     n_out_vld;
    t_frame   r_skid;
    t_frame   n_skid;
    logic     r_skid_vld;
    logic     n_skid_vld;

    // Configuration is always accepted; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_trailer <= TRAILER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEADER:  r_header  <= i_cfg_data;
                REG_TRAILER: r_trailer <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // A request is taken whenever the skid stage is free, so a frame that is
    // found always has somewhere to go.
    assign s_axis_tready = !r_skid_vld;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_take    = r_out_vld && m_axis_tready;

    cfd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_accept),
        .i_byte    (s_axis_tdata),
        .i_header  (r_header),
        .i_trailer (r_trailer),
        .o_res     (w_res)
    );

    // The output register refills from the skid stage first, which keeps the
    // frames in order; a new frame goes to the skid stage only while the
    // output register is occupied and not being taken.
    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (!r_out_vld || w_out_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out      = w_res.frame;
                n_out_vld  = w_res.hit;
            end
        end else if (w_res.hit) begin
            n_skid     = w_res.frame;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.payload_tail, r_out.payload_head,
                            r_out.length_code, r_out.frame_id};

    // The skid stage is only ever filled behind a waiting output frame.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage holds a frame while the output is empty");

    // A frame is never found while both output stages are full.
    a_hit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.hit |-> !r_skid_vld)
        else $error("frame found with no room to hold it");

    // After a frame is found, the output holds a valid frame in the next cycle.
    a_hit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.hit |=> r_out_vld)
        else $error("found frame did not reach the output");

endmodule
